// ----- rtl/evse_control_pilot_state_machine_defines.svh -----
// Assertion macros for the control pilot state machine checker.
// Depends on clk and rst_n being visible in the scope that uses them.
`ifndef EVSE_CONTROL_PILOT_STATE_MACHINE_DEFINES_SVH
`define EVSE_CONTROL_PILOT_STATE_MACHINE_DEFINES_SVH

// same-cycle implication
`define EVCP_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("control pilot check failed");

// next-cycle implication
`define EVCP_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("control pilot check failed");

`endif

// ----- rtl/evcp_pkg.sv -----
// Shared types, codes and constants for the control pilot state machine.
// No dependencies.
package evcp_pkg;

    localparam int unsigned REG_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned TS_W      = 32;
    localparam int unsigned OHM_W     = 16;
    localparam int unsigned MA_W      = 17;
    localparam int unsigned DUTY_W    = 10;
    localparam int unsigned CODE_W    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESH_A      = 3'd0,
        CFG_THRESH_B      = 3'd1,
        CFG_THRESH_C      = 3'd2,
        CFG_THRESH_D      = 3'd3,
        CFG_ERROR_HOLDOFF = 3'd4,
        CFG_QUIRK_HOLDOFF = 3'd5
    } cfg_idx_t;

    localparam logic [REG_W-1:0] RST_THRESH_A      = 16'd10000;
    localparam logic [REG_W-1:0] RST_THRESH_B      = 16'd2200;
    localparam logic [REG_W-1:0] RST_THRESH_C      = 16'd500;
    localparam logic [REG_W-1:0] RST_THRESH_D      = 16'd150;
    localparam logic [REG_W-1:0] RST_ERROR_HOLDOFF = 16'd30000;
    localparam logic [REG_W-1:0] RST_QUIRK_HOLDOFF = 16'd2500;

    typedef struct packed {
        logic [REG_W-1:0] thresh_a;
        logic [REG_W-1:0] thresh_b;
        logic [REG_W-1:0] thresh_c;
        logic [REG_W-1:0] thresh_d;
        logic [REG_W-1:0] error_holdoff;
        logic [REG_W-1:0] quirk_holdoff;
    } cfg_t;

    // pilot state codes as seen on the output
    localparam logic [CODE_W-1:0] PS_A = 3'd0;
    localparam logic [CODE_W-1:0] PS_B = 3'd1;
    localparam logic [CODE_W-1:0] PS_C = 3'd2;
    localparam logic [CODE_W-1:0] PS_D = 3'd3;
    localparam logic [CODE_W-1:0] PS_E = 3'd4;

    localparam logic [CODE_W-1:0] LED_NONE      = 3'd0;
    localparam logic [CODE_W-1:0] LED_ON        = 3'd1;
    localparam logic [CODE_W-1:0] LED_BREATHING = 3'd2;
    localparam logic [CODE_W-1:0] LED_BLINK2    = 3'd3;
    localparam logic [CODE_W-1:0] LED_BLINK4    = 3'd4;
    localparam logic [CODE_W-1:0] LED_BLINK5    = 3'd5;

    localparam logic [DUTY_W-1:0] DUTY_FULL   = 10'd1000;
    localparam logic [DUTY_W:0]   DUTY_MIN    = 11'd80;
    localparam logic [DUTY_W:0]   DUTY_MAX    = 11'd1000;
    localparam logic [DUTY_W:0]   DUTY_OFFSET = 11'd640;
    localparam logic [MA_W-1:0]   DUTY_SPLIT_MA = 17'd51000;

    // floor(x/60) and floor(x/250) by reciprocal, exact over the ranges used
    localparam logic [15:0] RECIP_60  = 16'd34953;
    localparam int unsigned RECIP_60_SHIFT = 21;
    localparam logic [16:0] RECIP_250 = 17'd67109;
    localparam int unsigned RECIP_250_SHIFT = 24;

    typedef enum logic [1:0] {
        TK_IGNORE = 2'd0,
        TK_FAULT  = 2'd1,
        TK_JUMPER = 2'd2,
        TK_NORMAL = 2'd3
    } tick_kind_t;

    typedef struct packed {
        tick_kind_t        kind;
        logic              quirk;
        logic              above_a3;
        logic              above_a;
        logic              above_b;
        logic              above_c;
        logic              above_d;
        logic              ma_zero;
        logic [DUTY_W-1:0] duty;
        logic [TS_W-1:0]   now_ms;
        logic              button_event;
        logic              button_up;
    } tick_t;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = 1;
    localparam int unsigned QUEUE_CNT_W = 2;

endpackage

// ----- rtl/evcp_front.sv -----
// Front end: classifies one tick against the thresholds and works out the duty.
// Depends on evcp_pkg.
module evcp_front
(
    input  evcp_pkg::cfg_t                    cfg,
    input  logic [evcp_pkg::TS_W-1:0]         now_ms,
    input  logic                              calibrating,
    input  logic                              contactor_fault,
    input  logic                              jumper_unset,
    input  logic                              adc_not_ready,
    input  logic [evcp_pkg::OHM_W-1:0]        cp_ohms,
    input  logic [evcp_pkg::DUTY_W-1:0]       pilot_duty_now,
    input  logic                              relay_closed,
    input  logic [evcp_pkg::MA_W-1:0]         allowed_ma,
    input  logic                              button_event,
    input  logic                              button_up,
    output evcp_pkg::tick_t                   tick
);

    logic [17:0]                     thr_a3;
    logic [32:0]                     prod60;
    logic [33:0]                     prod250;
    logic [evcp_pkg::DUTY_W:0]       q60;
    logic [evcp_pkg::DUTY_W:0]       q250;
    logic [evcp_pkg::DUTY_W:0]       duty_raw;
    logic [evcp_pkg::DUTY_W-1:0]     duty;

    assign thr_a3  = {2'b00, cfg.thresh_a} + {1'b0, cfg.thresh_a, 1'b0};
    assign prod60  = {16'd0, allowed_ma} * {17'd0, evcp_pkg::RECIP_60};
    assign prod250 = {17'd0, allowed_ma} * {17'd0, evcp_pkg::RECIP_250};
    assign q60     = prod60[evcp_pkg::RECIP_60_SHIFT +: 11];
    assign q250    = {1'b0, prod250[evcp_pkg::RECIP_250_SHIFT +: 10]};

    always_comb
    begin
        if (allowed_ma <= evcp_pkg::DUTY_SPLIT_MA)
        begin
            duty_raw = q60;
        end
        else
        begin
            duty_raw = q250 + evcp_pkg::DUTY_OFFSET;
        end

        if (allowed_ma == '0)
        begin
            duty = evcp_pkg::DUTY_FULL;
        end
        else if (duty_raw < evcp_pkg::DUTY_MIN)
        begin
            duty = evcp_pkg::DUTY_MIN[evcp_pkg::DUTY_W-1:0];
        end
        else if (duty_raw > evcp_pkg::DUTY_MAX)
        begin
            duty = evcp_pkg::DUTY_FULL;
        end
        else
        begin
            duty = duty_raw[evcp_pkg::DUTY_W-1:0];
        end
    end

    always_comb
    begin
        if (calibrating)
        begin
            tick.kind = evcp_pkg::TK_IGNORE;
        end
        else if (contactor_fault)
        begin
            tick.kind = evcp_pkg::TK_FAULT;
        end
        else if (jumper_unset)
        begin
            tick.kind = evcp_pkg::TK_JUMPER;
        end
        else if (adc_not_ready)
        begin
            tick.kind = evcp_pkg::TK_IGNORE;
        end
        else
        begin
            tick.kind = evcp_pkg::TK_NORMAL;
        end
        tick.quirk        = (pilot_duty_now != evcp_pkg::DUTY_FULL) && !relay_closed;
        tick.above_a3     = {2'b00, cp_ohms} > thr_a3;
        tick.above_a      = cp_ohms > cfg.thresh_a;
        tick.above_b      = cp_ohms > cfg.thresh_b;
        tick.above_c      = cp_ohms > cfg.thresh_c;
        tick.above_d      = cp_ohms > cfg.thresh_d;
        tick.ma_zero      = allowed_ma == '0;
        tick.duty         = duty;
        tick.now_ms       = now_ms;
        tick.button_event = button_event;
        tick.button_up    = button_up;
    end

endmodule

// ----- rtl/evcp_queue.sv -----
// Two-entry queue between the classifier and the state machine.
// Depends on evcp_pkg.
module evcp_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  evcp_pkg::tick_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output evcp_pkg::tick_t rd_data,
    output logic            empty
);

    evcp_pkg::tick_t                     mem_reg [evcp_pkg::QUEUE_DEPTH];
    logic [evcp_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [evcp_pkg::QUEUE_PTR_W-1:0]    wr_ptr_next;
    logic [evcp_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [evcp_pkg::QUEUE_PTR_W-1:0]    rd_ptr_next;
    logic [evcp_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [evcp_pkg::QUEUE_CNT_W-1:0]    count_next;

    assign full    = count_reg == evcp_pkg::QUEUE_CNT_W'(evcp_pkg::QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/evcp_back.sv -----
// Back end: pilot state machine, timers and the registered result stage.
// Depends on evcp_pkg.
module evcp_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  evcp_pkg::cfg_t                   cfg,
    input  logic                             tick_valid,
    input  evcp_pkg::tick_t                  tick,
    output logic                             tick_take,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             ignored,
    output logic [evcp_pkg::CODE_W-1:0]      pilot_state,
    output logic [evcp_pkg::DUTY_W-1:0]      pilot_duty,
    output logic                             contactor_on,
    output logic [evcp_pkg::CODE_W-1:0]      led_cmd,
    output logic                             disconnect_event,
    output logic                             button_ack,
    output logic                             button_start,
    output logic [evcp_pkg::TS_W-1:0]        charge_start_ms
);

    typedef enum logic [4:0] {
        S_A = 5'b00001,
        S_B = 5'b00010,
        S_C = 5'b00100,
        S_D = 5'b01000,
        S_E = 5'b10000
    } pstate_t;

    function automatic logic [evcp_pkg::CODE_W-1:0] state_code(input pstate_t s);
        logic [evcp_pkg::CODE_W-1:0] c;
        case (s)
            S_A:     c = evcp_pkg::PS_A;
            S_B:     c = evcp_pkg::PS_B;
            S_C:     c = evcp_pkg::PS_C;
            S_D:     c = evcp_pkg::PS_D;
            default: c = evcp_pkg::PS_E;
        endcase
        return c;
    endfunction

    pstate_t                         state_reg, state_next;
    logic                            err_valid_reg, err_valid_next;
    logic [evcp_pkg::TS_W-1:0]       err_ms_reg, err_ms_next;
    logic                            quirk_valid_reg, quirk_valid_next;
    logic [evcp_pkg::TS_W-1:0]       quirk_ms_reg, quirk_ms_next;
    logic                            chg_valid_reg, chg_valid_next;
    logic [evcp_pkg::TS_W-1:0]       chg_ms_reg, chg_ms_next;
    logic [evcp_pkg::CODE_W-1:0]     led_reg, led_next;
    logic [evcp_pkg::DUTY_W-1:0]     duty_reg, duty_next;
    logic                            cont_reg, cont_next;
    logic                            out_valid_reg, out_valid_next;

    logic                            ignored_reg;
    logic [evcp_pkg::CODE_W-1:0]     pilot_state_reg;
    logic [evcp_pkg::DUTY_W-1:0]     pilot_duty_reg;
    logic                            contactor_on_reg;
    logic [evcp_pkg::CODE_W-1:0]     led_cmd_reg;
    logic                            disconnect_event_reg;
    logic                            button_ack_reg;
    logic                            button_start_reg;
    logic [evcp_pkg::TS_W-1:0]       charge_start_ms_reg;

    logic                            advance;
    logic                            ign, disc, ack, start, req;
    pstate_t                         target;
    logic [evcp_pkg::TS_W-1:0]       err_elapsed;
    logic [evcp_pkg::TS_W-1:0]       quirk_elapsed;

    assign advance   = tick_valid && (!out_valid_reg || out_ready);
    assign tick_take = advance;

    // leaving error in this tick makes the leave time now
    assign err_elapsed   = tick.now_ms - ((state_reg == S_E) ? tick.now_ms : err_ms_reg);
    assign quirk_elapsed = tick.now_ms - quirk_ms_reg;

    always_comb
    begin
        state_next       = state_reg;
        err_valid_next   = err_valid_reg;
        err_ms_next      = err_ms_reg;
        quirk_valid_next = quirk_valid_reg;
        quirk_ms_next    = quirk_ms_reg;
        chg_valid_next   = chg_valid_reg;
        chg_ms_next      = chg_ms_reg;
        led_next         = led_reg;
        duty_next        = duty_reg;
        cont_next        = cont_reg;
        ign              = 1'b0;
        disc             = 1'b0;
        ack              = 1'b0;
        start            = 1'b0;
        req              = 1'b0;
        target           = S_A;

        case (tick.kind)
            evcp_pkg::TK_FAULT:
            begin
                led_next = evcp_pkg::LED_BLINK4;
                req      = 1'b1;
                target   = S_E;
            end
            evcp_pkg::TK_JUMPER:
            begin
                led_next = evcp_pkg::LED_BLINK2;
                req      = 1'b1;
                target   = S_E;
            end
            evcp_pkg::TK_NORMAL:
            begin
                if (!tick.quirk)
                begin
                    quirk_valid_next = 1'b0;
                end
                if (tick.quirk && tick.above_a3)
                begin
                    if (!quirk_valid_reg)
                    begin
                        quirk_ms_next    = tick.now_ms;
                        quirk_valid_next = 1'b1;
                    end
                    else if (quirk_elapsed >= {16'd0, cfg.quirk_holdoff})
                    begin
                        req    = 1'b1;
                        target = S_A;
                    end
                end
                else if (!tick.quirk && tick.above_a)
                begin
                    req    = 1'b1;
                    target = S_A;
                end
                else if (tick.above_b)
                begin
                    req    = 1'b1;
                    target = S_B;
                end
                else if (tick.above_c)
                begin
                    req = 1'b1;
                    if (tick.ma_zero)
                    begin
                        chg_valid_next = 1'b0;
                        chg_ms_next    = '0;
                        target         = S_B;
                    end
                    else
                    begin
                        target = S_C;
                    end
                end
                else if (tick.above_d)
                begin
                    led_next = evcp_pkg::LED_BLINK5;
                    req      = 1'b1;
                    target   = S_D;
                end
                else
                begin
                    led_next = evcp_pkg::LED_BLINK5;
                    req      = 1'b1;
                    target   = S_E;
                end
            end
            default:
            begin
                ign = 1'b1;
            end
        endcase

        if (req && (target != state_reg))
        begin
            if (state_reg == S_E)
            begin
                err_ms_next    = tick.now_ms;
                err_valid_next = 1'b1;
            end
            if (!((target == S_C) && err_valid_next
                  && (err_elapsed < {16'd0, cfg.error_holdoff})))
            begin
                if ((target == S_C) && err_valid_next)
                begin
                    err_valid_next = 1'b0;
                    err_ms_next    = '0;
                end
                if ((target == S_C) && !chg_valid_next)
                begin
                    chg_ms_next    = tick.now_ms;
                    chg_valid_next = 1'b1;
                end
                if ((target == S_A) || (target == S_B))
                begin
                    led_next = evcp_pkg::LED_ON;
                end
                if (target == S_A)
                begin
                    disc           = 1'b1;
                    chg_valid_next = 1'b0;
                    chg_ms_next    = '0;
                end
                state_next = target;
            end
        end

        if (!ign)
        begin
            case (state_next)
                S_A:
                begin
                    ack       = tick.button_event;
                    start     = tick.button_event && tick.button_up;
                    duty_next = evcp_pkg::DUTY_FULL;
                    cont_next = 1'b0;
                end
                S_B:
                begin
                    duty_next = tick.duty;
                    cont_next = 1'b0;
                end
                S_C:
                begin
                    duty_next = tick.duty;
                    cont_next = 1'b1;
                    led_next  = evcp_pkg::LED_BREATHING;
                end
                default:
                begin
                    duty_next = evcp_pkg::DUTY_FULL;
                    cont_next = 1'b0;
                end
            endcase
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_A;
            err_valid_reg   <= 1'b0;
            err_ms_reg      <= '0;
            quirk_valid_reg <= 1'b0;
            quirk_ms_reg    <= '0;
            chg_valid_reg   <= 1'b0;
            chg_ms_reg      <= '0;
            led_reg         <= evcp_pkg::LED_NONE;
            duty_reg        <= evcp_pkg::DUTY_FULL;
            cont_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg       <= state_next;
                err_valid_reg   <= err_valid_next;
                err_ms_reg      <= err_ms_next;
                quirk_valid_reg <= quirk_valid_next;
                quirk_ms_reg    <= quirk_ms_next;
                chg_valid_reg   <= chg_valid_next;
                chg_ms_reg      <= chg_ms_next;
                led_reg         <= led_next;
                duty_reg        <= duty_next;
                cont_reg        <= cont_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ignored_reg          <= ign;
            pilot_state_reg      <= state_code(state_next);
            pilot_duty_reg       <= duty_next;
            contactor_on_reg     <= cont_next;
            led_cmd_reg          <= led_next;
            disconnect_event_reg <= disc;
            button_ack_reg       <= ack;
            button_start_reg     <= start;
            charge_start_ms_reg  <= chg_valid_next ? chg_ms_next : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign ignored          = ignored_reg;
    assign pilot_state      = pilot_state_reg;
    assign pilot_duty       = pilot_duty_reg;
    assign contactor_on     = contactor_on_reg;
    assign led_cmd          = led_cmd_reg;
    assign disconnect_event = disconnect_event_reg;
    assign button_ack       = button_ack_reg;
    assign button_start     = button_start_reg;
    assign charge_start_ms  = charge_start_ms_reg;

endmodule

// ----- rtl/evse_control_pilot_state_machine.sv -----
// Control pilot state machine, top level: register bank, classifier, queue, state machine.
// Depends on evcp_pkg, evcp_front, evcp_queue and evcp_back.
// An input tick goes into the queue and then into the back end's registered result stage;
// one tick per cycle sustained while no result is held at the output.
// A held result stops the back end; input stalls once the two-entry queue is full.
// Reset: state A, all timers idle, LED none, duty 1000, registers at their defaults.
module evse_control_pilot_state_machine
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [evcp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [evcp_pkg::REG_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [evcp_pkg::TS_W-1:0]             now_ms,
    input  logic                                  calibrating,
    input  logic                                  contactor_fault,
    input  logic                                  jumper_unset,
    input  logic                                  adc_not_ready,
    input  logic [evcp_pkg::OHM_W-1:0]            cp_ohms,
    input  logic [evcp_pkg::DUTY_W-1:0]           pilot_duty_now,
    input  logic                                  relay_closed,
    input  logic [evcp_pkg::MA_W-1:0]             allowed_ma,
    input  logic                                  button_event,
    input  logic                                  button_up,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  ignored,
    output logic [evcp_pkg::CODE_W-1:0]           pilot_state,
    output logic [evcp_pkg::DUTY_W-1:0]           pilot_duty,
    output logic                                  contactor_on,
    output logic [evcp_pkg::CODE_W-1:0]           led_cmd,
    output logic                                  disconnect_event,
    output logic                                  button_ack,
    output logic                                  button_start,
    output logic [evcp_pkg::TS_W-1:0]             charge_start_ms
);

    evcp_pkg::cfg_t  cfg_reg;
    evcp_pkg::tick_t front_tick;
    evcp_pkg::tick_t queue_tick;
    logic            queue_full;
    logic            queue_empty;
    logic            tick_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thresh_a      <= evcp_pkg::RST_THRESH_A;
            cfg_reg.thresh_b      <= evcp_pkg::RST_THRESH_B;
            cfg_reg.thresh_c      <= evcp_pkg::RST_THRESH_C;
            cfg_reg.thresh_d      <= evcp_pkg::RST_THRESH_D;
            cfg_reg.error_holdoff <= evcp_pkg::RST_ERROR_HOLDOFF;
            cfg_reg.quirk_holdoff <= evcp_pkg::RST_QUIRK_HOLDOFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                evcp_pkg::CFG_THRESH_A:      cfg_reg.thresh_a      <= cfg_data;
                evcp_pkg::CFG_THRESH_B:      cfg_reg.thresh_b      <= cfg_data;
                evcp_pkg::CFG_THRESH_C:      cfg_reg.thresh_c      <= cfg_data;
                evcp_pkg::CFG_THRESH_D:      cfg_reg.thresh_d      <= cfg_data;
                evcp_pkg::CFG_ERROR_HOLDOFF: cfg_reg.error_holdoff <= cfg_data;
                evcp_pkg::CFG_QUIRK_HOLDOFF: cfg_reg.quirk_holdoff <= cfg_data;
                default:                     ;
            endcase
        end
    end

    assign in_ready = !queue_full;

    evcp_front u_front
    (
        .cfg             (cfg_reg),
        .now_ms          (now_ms),
        .calibrating     (calibrating),
        .contactor_fault (contactor_fault),
        .jumper_unset    (jumper_unset),
        .adc_not_ready   (adc_not_ready),
        .cp_ohms         (cp_ohms),
        .pilot_duty_now  (pilot_duty_now),
        .relay_closed    (relay_closed),
        .allowed_ma      (allowed_ma),
        .button_event    (button_event),
        .button_up       (button_up),
        .tick            (front_tick)
    );

    evcp_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_valid && in_ready),
        .wr_data (front_tick),
        .full    (queue_full),
        .rd_en   (tick_take),
        .rd_data (queue_tick),
        .empty   (queue_empty)
    );

    evcp_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .tick_valid       (!queue_empty),
        .tick             (queue_tick),
        .tick_take        (tick_take),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .ignored          (ignored),
        .pilot_state      (pilot_state),
        .pilot_duty       (pilot_duty),
        .contactor_on     (contactor_on),
        .led_cmd          (led_cmd),
        .disconnect_event (disconnect_event),
        .button_ack       (button_ack),
        .button_start     (button_start),
        .charge_start_ms  (charge_start_ms)
    );

endmodule

// ----- rtl/evcp_checker.sv -----
// Port-level checks on the control pilot state machine results, bound to the top level.
// Depends on evcp_pkg and the assertion macro header.
`include "evse_control_pilot_state_machine_defines.svh"

module evcp_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            ignored,
    input logic [evcp_pkg::CODE_W-1:0]     pilot_state,
    input logic                            contactor_on,
    input logic                            disconnect_event,
    input logic                            button_ack,
    input logic                            button_start,
    input logic [evcp_pkg::TS_W-1:0]       charge_start_ms
);

    `EVCP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(pilot_state) && $stable(charge_start_ms))
    `EVCP_ASSERT_NOW(a_contactor_in_c, out_valid && contactor_on, pilot_state == evcp_pkg::PS_C)
    `EVCP_ASSERT_NOW(a_skip_no_events, out_valid && ignored, !disconnect_event && !button_ack && !button_start)
    `EVCP_ASSERT_NOW(a_button_in_a, out_valid && (button_ack || button_start), pilot_state == evcp_pkg::PS_A && button_ack)
    `EVCP_ASSERT_NOW(a_disconnect_clears, out_valid && disconnect_event, pilot_state == evcp_pkg::PS_A && charge_start_ms == '0)

endmodule

bind evse_control_pilot_state_machine evcp_checker u_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .ignored          (ignored),
    .pilot_state      (pilot_state),
    .contactor_on     (contactor_on),
    .disconnect_event (disconnect_event),
    .button_ack       (button_ack),
    .button_start     (button_start),
    .charge_start_ms  (charge_start_ms)
);
